@@ rtl/core/ctk_pkg.sv @@
// Package for the C subset tokenizer core: token class codes, keyword table,
// queue sizing and the classification functions shared by the front end.
// No dependencies.
package ctk_pkg;

  // Token classes as carried on the result channel.
  localparam logic [2:0] CLS_NUMBER  = 3'd0;
  localparam logic [2:0] CLS_KEYWORD = 3'd1;
  localparam logic [2:0] CLS_IDENT   = 3'd2;
  localparam logic [2:0] CLS_ARITH   = 3'd3;
  localparam logic [2:0] CLS_COMPARE = 3'd4;
  localparam logic [2:0] CLS_RELATE  = 3'd5;
  localparam logic [2:0] CLS_SEP     = 3'd6;
  localparam logic [2:0] CLS_OTHER   = 3'd7;

  // Number of letters held for keyword matching.
  localparam int HELD_MAX = 6;

  // Keyword table: letter k sits in bits 8k+7..8k, unused lanes are zero.
  localparam int KW_COUNT = 11;
  localparam logic [47:0] KW_WORD [KW_COUNT] = '{
    48'h0000_0000_6F64,  // do
    48'h0065_6C69_6877,  // while
    48'h0000_0000_6669,  // if
    48'h0000_6573_6C65,  // else
    48'h0000_6E65_6874,  // then
    48'h0000_0074_6E69,  // int
    48'h656C_6275_6F64,  // double
    48'h0074_616F_6C66,  // float
    48'h0074_736E_6F63,  // const
    48'h6E72_7574_6572,  // return
    48'h0000_6E69_616D   // main
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd5, 3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd5, 3'd6, 3'd4
  };

  // Depth of the result queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Class and index of one token.
  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] code;
  } tok_kind_t;

  // Class of a byte that forms a token on its own.
  function automatic tok_kind_t single_class(input logic [7:0] b);
    tok_kind_t k;
    k.cls  = CLS_OTHER;
    k.code = 4'd0;
    case (b)
      "+": begin k.cls = CLS_ARITH;   k.code = 4'd0;  end
      "-": begin k.cls = CLS_ARITH;   k.code = 4'd1;  end
      "*": begin k.cls = CLS_ARITH;   k.code = 4'd2;  end
      "/": begin k.cls = CLS_ARITH;   k.code = 4'd3;  end
      "%": begin k.cls = CLS_ARITH;   k.code = 4'd4;  end
      "&": begin k.cls = CLS_ARITH;   k.code = 4'd5;  end
      "|": begin k.cls = CLS_ARITH;   k.code = 4'd6;  end
      "^": begin k.cls = CLS_ARITH;   k.code = 4'd7;  end
      "~": begin k.cls = CLS_ARITH;   k.code = 4'd8;  end
      "!": begin k.cls = CLS_ARITH;   k.code = 4'd9;  end
      "=": begin k.cls = CLS_ARITH;   k.code = 4'd10; end
      "<": begin k.cls = CLS_COMPARE; k.code = 4'd0;  end
      ">": begin k.cls = CLS_COMPARE; k.code = 4'd2;  end
      ",": begin k.cls = CLS_SEP;     k.code = 4'd0;  end
      ";": begin k.cls = CLS_SEP;     k.code = 4'd1;  end
      "(": begin k.cls = CLS_SEP;     k.code = 4'd2;  end
      ")": begin k.cls = CLS_SEP;     k.code = 4'd3;  end
      "{": begin k.cls = CLS_SEP;     k.code = 4'd4;  end
      "}": begin k.cls = CLS_SEP;     k.code = 4'd5;  end
      default: begin k.cls = CLS_OTHER; k.code = 4'd0; end
    endcase
    return k;
  endfunction

  // Class of a letter run: keyword when the held letters and length match.
  function automatic tok_kind_t word_kind(input logic [47:0] letters,
                                          input logic [2:0] len,
                                          input logic short_run);
    tok_kind_t k;
    k.cls  = CLS_IDENT;
    k.code = 4'd0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (short_run && (len == KW_LEN[i]) && (letters == KW_WORD[i])) begin
        k.cls  = CLS_KEYWORD;
        k.code = 4'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ rtl/core/ctk_if.sv @@
// Channel interfaces of the C subset tokenizer core: source bytes in,
// tokens out. No dependencies.

// Input channel: one source byte per transaction.
interface ctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface

// Result channel: one token per transaction.
interface ctk_out_if #(
  parameter int LINE_WIDTH   = 20,
  parameter int LENGTH_WIDTH = 16,
  parameter int OFFSET_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              token_class;
  logic [3:0]              token_code;
  logic [LINE_WIDTH-1:0]   line_number;
  logic [OFFSET_WIDTH-1:0] start_offset;
  logic [LENGTH_WIDTH-1:0] token_length;
  logic                    last_in_run;

  modport source (output valid, output token_class, output token_code,
                  output line_number, output start_offset, output token_length,
                  output last_in_run, input ready);
  modport sink   (input valid, input token_class, input token_code,
                  input line_number, input start_offset, input token_length,
                  input last_in_run, output ready);
endinterface

@@ rtl/core/ctk_front.sv @@
// Front end of the tokenizer: scans one byte per transaction, keeps the run
// state and builds the up to two tokens each byte causes. Uses ctk_pkg.
module ctk_front import ctk_pkg::*; #(
  parameter int LINE_WIDTH   = 20,
  parameter int LENGTH_WIDTH = 16,
  parameter int OFFSET_WIDTH = 32,
  localparam int RES_W = 3 + 4 + LINE_WIDTH + OFFSET_WIDTH + LENGTH_WIDTH + 1,
  localparam int ENT_W = 2 * RES_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       byte_value,
  input  logic             final_byte,
  input  logic             q_space,
  output logic             push,
  output logic [ENT_W-1:0] push_entry
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_WORD   = 2'd2;
  localparam logic [1:0] MODE_OPER   = 2'd3;

  typedef struct packed {
    logic [2:0]              cls;
    logic [3:0]              code;
    logic [LINE_WIDTH-1:0]   line;
    logic [OFFSET_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    last;
  } res_t;

  logic [1:0]              mode_r, mode_nxt, mode_mid;
  logic [7:0]              held_r, held_mid;
  logic [47:0]             letters_r, letters_mid;
  logic [LENGTH_WIDTH-1:0] run_r, run_mid, run_inc;
  logic [OFFSET_WIDTH-1:0] start_r, start_mid;
  logic [OFFSET_WIDTH-1:0] count_r, count_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;

  logic      is_digit, is_letter, is_nl, is_blank, is_opstart;
  logic      pair_v;
  tok_kind_t pair_kind;
  logic      used;
  logic      accept;

  // First token: the run or operator that this byte ends.
  logic                    p0_v;
  tok_kind_t               p0_kind;
  logic [LENGTH_WIDTH-1:0] p0_len;
  // Second token: a lone single-byte token or the flush after a final byte.
  logic                    q_v;
  tok_kind_t               q_kind;
  logic [OFFSET_WIDTH-1:0] q_start;
  logic [LENGTH_WIDTH-1:0] q_len;

  res_t slot0, slot1;
  logic has1;

  assign accept   = in_valid && in_ready;
  assign in_ready = q_space;

  // Byte classes.
  assign is_digit   = (byte_value >= "0") && (byte_value <= "9");
  assign is_letter  = ((byte_value >= "a") && (byte_value <= "z")) ||
                      ((byte_value >= "A") && (byte_value <= "Z"));
  assign is_nl      = (byte_value == 8'h0A);
  assign is_blank   = (byte_value == " ") || (byte_value == 8'h09) ||
                      (byte_value == 8'h0D) || (byte_value == 8'h0B) ||
                      (byte_value == 8'h0C);
  assign is_opstart = (byte_value == "<") || (byte_value == ">") ||
                      (byte_value == "=") || (byte_value == "!") ||
                      (byte_value == "&") || (byte_value == "|");

  assign run_inc = (run_r == {LENGTH_WIDTH{1'b1}}) ? run_r : run_r + 1'b1;

  // Two-byte operators formed with the held byte.
  always_comb begin
    pair_v         = 1'b1;
    pair_kind.cls  = CLS_COMPARE;
    pair_kind.code = 4'd0;
    if (byte_value == "=" && held_r == "<") begin
      pair_kind.code = 4'd1;
    end else if (byte_value == "=" && held_r == ">") begin
      pair_kind.code = 4'd3;
    end else if (byte_value == "=" && held_r == "=") begin
      pair_kind.code = 4'd4;
    end else if (byte_value == "=" && held_r == "!") begin
      pair_kind.code = 4'd5;
    end else if (byte_value == "&" && held_r == "&") begin
      pair_kind.cls  = CLS_RELATE;
      pair_kind.code = 4'd0;
    end else if (byte_value == "|" && held_r == "|") begin
      pair_kind.cls  = CLS_RELATE;
      pair_kind.code = 4'd1;
    end else begin
      pair_v = 1'b0;
    end
  end

  // Scan step: end the current run, start a new one, then flush on a final byte.
  always_comb begin
    used        = 1'b0;
    p0_v        = 1'b0;
    p0_kind     = single_class(held_r);
    p0_len      = run_r;
    q_v         = 1'b0;
    q_kind      = single_class(byte_value);
    q_start     = count_r;
    q_len       = LENGTH_WIDTH'(1);
    mode_mid    = MODE_IDLE;
    held_mid    = held_r;
    letters_mid = letters_r;
    run_mid     = run_r;
    start_mid   = start_r;
    line_nxt    = line_r;

    case (mode_r)
      MODE_OPER: begin
        p0_v = 1'b1;
        if (pair_v) begin
          used    = 1'b1;
          p0_kind = pair_kind;
          p0_len  = LENGTH_WIDTH'(2);
        end else begin
          p0_len = LENGTH_WIDTH'(1);
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          used     = 1'b1;
          mode_mid = MODE_NUMBER;
          run_mid  = run_inc;
        end else begin
          p0_v         = 1'b1;
          p0_kind.cls  = CLS_NUMBER;
          p0_kind.code = 4'd0;
        end
      end
      MODE_WORD: begin
        if (is_letter) begin
          used     = 1'b1;
          mode_mid = MODE_WORD;
          run_mid  = run_inc;
          for (int k = 0; k < HELD_MAX; k++) begin
            if (run_r == LENGTH_WIDTH'(k)) letters_mid[8*k +: 8] = byte_value;
          end
        end else begin
          p0_v    = 1'b1;
          p0_kind = word_kind(letters_r, run_r[2:0],
                              run_r <= LENGTH_WIDTH'(HELD_MAX));
        end
      end
      default: ;
    endcase

    // The byte was not absorbed by a run, so it is scanned afresh.
    if (!used) begin
      if (is_digit) begin
        mode_mid  = MODE_NUMBER;
        start_mid = count_r;
        run_mid   = LENGTH_WIDTH'(1);
      end else if (is_letter) begin
        mode_mid    = MODE_WORD;
        start_mid   = count_r;
        run_mid     = LENGTH_WIDTH'(1);
        letters_mid = {40'd0, byte_value};
      end else if (is_nl) begin
        line_nxt = (line_r == {LINE_WIDTH{1'b1}}) ? line_r : line_r + 1'b1;
      end else if (is_blank) begin
        mode_mid = MODE_IDLE;
      end else if (is_opstart) begin
        mode_mid  = MODE_OPER;
        held_mid  = byte_value;
        start_mid = count_r;
        run_mid   = LENGTH_WIDTH'(1);
      end else begin
        q_v = 1'b1;
      end
    end

    // A final byte flushes whatever is pending after the step.
    mode_nxt = final_byte ? MODE_IDLE : mode_mid;
    if (final_byte) begin
      case (mode_mid)
        MODE_NUMBER: begin
          q_v         = 1'b1;
          q_kind.cls  = CLS_NUMBER;
          q_kind.code = 4'd0;
          q_start     = start_mid;
          q_len       = run_mid;
        end
        MODE_WORD: begin
          q_v     = 1'b1;
          q_kind  = word_kind(letters_mid, run_mid[2:0],
                              run_mid <= LENGTH_WIDTH'(HELD_MAX));
          q_start = start_mid;
          q_len   = run_mid;
        end
        MODE_OPER: begin
          q_v     = 1'b1;
          q_kind  = single_class(held_mid);
          q_start = start_mid;
          q_len   = LENGTH_WIDTH'(1);
        end
        default: ;
      endcase
    end
  end

  assign count_nxt = (count_r == {OFFSET_WIDTH{1'b1}}) ? count_r : count_r + 1'b1;

  // Pack the tokens into one queue entry; all use the line before this byte.
  assign has1 = p0_v && q_v;

  always_comb begin
    slot0.cls   = p0_v ? p0_kind.cls  : q_kind.cls;
    slot0.code  = p0_v ? p0_kind.code : q_kind.code;
    slot0.line  = line_r;
    slot0.start = p0_v ? start_r : q_start;
    slot0.len   = p0_v ? p0_len  : q_len;
    slot0.last  = !has1;
    slot1.cls   = q_kind.cls;
    slot1.code  = q_kind.code;
    slot1.line  = line_r;
    slot1.start = q_start;
    slot1.len   = q_len;
    slot1.last  = 1'b1;
  end

  assign push       = accept && (p0_v || q_v);
  assign push_entry = {has1, slot1, slot0};

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      held_r    <= 8'd0;
      letters_r <= 48'd0;
      run_r     <= '0;
      start_r   <= '0;
      count_r   <= '0;
      line_r    <= LINE_WIDTH'(1);
    end else if (accept) begin
      mode_r    <= mode_nxt;
      held_r    <= held_mid;
      letters_r <= letters_mid;
      run_r     <= run_mid;
      start_r   <= start_mid;
      count_r   <= count_nxt;
      line_r    <= line_nxt;
    end
  end

endmodule

@@ rtl/core/ctk_queue.sv @@
// Short register queue that decouples the tokenizer front end from the
// output side. Uses ctk_pkg for its depth.
module ctk_queue import ctk_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             nonempty,
  output logic             space
);

  logic [WIDTH-1:0]       mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  assign nonempty = (cnt_r != '0);
  assign space    = (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/ctk_back.sv @@
// Back end of the tokenizer: takes queue entries of one or two tokens and
// sends them out one per transaction from an output register. Uses ctk_pkg.
module ctk_back import ctk_pkg::*; #(
  parameter int RES_W = 8,
  localparam int ENT_W = 2 * RES_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [ENT_W-1:0] head,
  input  logic             q_nonempty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] out_res
);

  logic [ENT_W-1:0] ent_r;
  logic             ent_v_r;
  logic             sel_r;
  logic             has1, fire, done;

  assign has1      = ent_r[ENT_W-1];
  assign fire      = ent_v_r && out_ready;
  assign done      = fire && (sel_r || !has1);
  assign pop       = q_nonempty && (!ent_v_r || done);
  assign out_valid = ent_v_r;
  assign out_res   = sel_r ? ent_r[2*RES_W-1:RES_W] : ent_r[RES_W-1:0];

  // Entry payload.
  always_ff @(posedge clk) begin
    if (pop) ent_r <= head;
  end

  // Entry valid and slot select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (pop) begin
      ent_v_r <= 1'b1;
      sel_r   <= 1'b0;
    end else if (done) begin
      ent_v_r <= 1'b0;
      sel_r   <= 1'b0;
    end else if (fire) begin
      sel_r <= 1'b1;
    end
  end

endmodule

@@ rtl/core/c_subset_tokenizer_core.sv @@
// Top level of the C subset tokenizer core: front end, result queue and back end.
// Uses ctk_pkg, ctk_in_if, ctk_out_if, ctk_front, ctk_queue and ctk_back.
//
// Usage: in_chan takes one source byte per transaction, with final_byte set on
// the last byte of a stream to flush the pending token. out_chan gives one
// token per transaction: class, code, line, start offset, length, and
// last_in_run on the last token caused by a byte. A byte causes zero, one or
// two tokens.
// A token caused by an accepted byte is written into the queue, then loaded
// into the output register, from which out_chan offers it. Throughput: one
// byte per cycle while the queue has space. Output is one token per cycle, so
// two tokens of one byte need two transfers; the four-entry queue absorbs this.
// When the receiver stalls, tokens collect in the queue; once it holds four
// entries in_chan.ready drops until the output stage has sent every token of
// its current entry and takes the next entry from the queue.
// Reset (rst_n low, synchronous) empties the queue and the output stage and
// returns the scanner to idle at line 1, offset 0.
module c_subset_tokenizer_core import ctk_pkg::*; #(
  parameter int LINE_WIDTH   = 20,
  parameter int LENGTH_WIDTH = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ctk_in_if.sink     in_chan,
  ctk_out_if.source  out_chan
);

  localparam int RES_W = 3 + 4 + LINE_WIDTH + OFFSET_WIDTH + LENGTH_WIDTH + 1;
  localparam int ENT_W = 2 * RES_W + 1;

  typedef struct packed {
    logic [2:0]              cls;
    logic [3:0]              code;
    logic [LINE_WIDTH-1:0]   line;
    logic [OFFSET_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    last;
  } res_t;

  logic             q_space, q_nonempty, push, pop;
  logic [ENT_W-1:0] push_entry, head;
  res_t             res;

  // Scanner.
  ctk_front #(
    .LINE_WIDTH   (LINE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .byte_value (in_chan.byte_value),
    .final_byte (in_chan.final_byte),
    .q_space    (q_space),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  ctk_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head),
    .nonempty  (q_nonempty),
    .space     (q_space)
  );

  // Output stage.
  ctk_back #(
    .RES_W (RES_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_nonempty (q_nonempty),
    .pop        (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_res    (res)
  );

  // Result fields onto the output channel.
  assign out_chan.token_class  = res.cls;
  assign out_chan.token_code   = res.code;
  assign out_chan.line_number  = res.line;
  assign out_chan.start_offset = res.start;
  assign out_chan.token_length = res.len;
  assign out_chan.last_in_run  = res.last;

endmodule
